>>> hdl/m3ph_pkg.sv
// shared types and constants for the murmur3 partition hasher
package m3ph_pkg;

  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_LEN_W = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RESET = 32'd42;

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_HASH_SEED = 2'd0;
  localparam logic [1:0] REG_PART_COUNT = 2'd1;
  localparam logic [1:0] REG_LOCAL_PART = 2'd2;

  typedef struct packed {
    logic [31:0]          seed;
    logic [31:0]          word;
    logic                 full;
    logic                 last;
    logic [KEY_LEN_W-1:0] key_len;
    logic                 ovf;
  } m3ph_entry_t;

endpackage

>>> hdl/murmur3_partition_hasher_top.sv
// top level: config registers, front end, queue and hash engine
// result path: a key's last byte is queued, then the engine mixes the tail word, runs the
// finalizer and the bit-serial remainder, and out_valid is registered from S_OUT
// input: one byte per cycle while the queue is not full; the engine mixes each word in
// S_IDLE, S_MUL1, S_MUL2 and S_MIX, and a key end holds it through S_FIN0..S_FIN3 and S_DIV
// reset: synchronous active high, clears control state and loads register defaults
module murmur3_partition_hasher_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    key_byte,
  input  logic                          key_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   key_hash,
  output logic [15:0]                   home_partition,
  output logic                          is_local,
  output logic                          length_overflow,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [m3ph_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import m3ph_pkg::*;

  logic [31:0] hash_seed;
  logic [15:0] partition_count;
  logic [15:0] local_partition;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  logic        in_accept;
  m3ph_entry_t push_entry;
  m3ph_entry_t head_entry;

  assign pready = 1'b1;
  assign in_stall = q_full;
  assign in_accept = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= SEED_RESET;
      partition_count <= 16'd1;
      local_partition <= 16'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_HASH_SEED:  hash_seed <= pwdata;
        REG_PART_COUNT: partition_count <= pwdata[15:0];
        REG_LOCAL_PART: local_partition <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HASH_SEED:  prdata = hash_seed;
      REG_PART_COUNT: prdata = {16'd0, partition_count};
      REG_LOCAL_PART: prdata = {16'd0, local_partition};
      default:        prdata = 32'd0;
    endcase
  end

  m3ph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .key_byte  (key_byte),
    .key_last  (key_last),
    .hash_seed (hash_seed),
    .push      (q_push),
    .entry     (push_entry)
  );

  m3ph_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  m3ph_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (head_entry),
    .q_pop           (q_pop),
    .partition_count (partition_count),
    .local_partition (local_partition),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .key_hash        (key_hash),
    .home_partition  (home_partition),
    .is_local        (is_local),
    .length_overflow (length_overflow)
  );

endmodule

>>> hdl/m3ph_front.sv
// front end: packs key bytes into words and queues word and key-end entries
module m3ph_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            key_byte,
  input  logic                  key_last,
  input  logic [31:0]           hash_seed,
  output logic                  push,
  output m3ph_pkg::m3ph_entry_t entry
);
  import m3ph_pkg::*;

  logic [31:0]          word_assembly;
  logic [1:0]           byte_in_word;
  logic [KEY_LEN_W-1:0] key_length;
  logic                 overflow_seen;
  logic [31:0]          key_seed;

  logic [31:0]          word_next;
  logic [KEY_LEN_W-1:0] key_length_next;
  logic                 overflow_next;
  logic                 word_done;
  logic [31:0]          seed_next;

  always_comb begin
    word_next = word_assembly | (32'(key_byte) << {byte_in_word, 3'b000});
    if (key_length < MAX_LEN) begin
      key_length_next = key_length + KEY_LEN_W'(1);
      overflow_next = overflow_seen;
    end else begin
      key_length_next = key_length;
      overflow_next = 1'b1;
    end
    // seed is taken at the first byte of each key
    seed_next = (key_length == '0) ? hash_seed : key_seed;
    word_done = (byte_in_word == 2'd3);
    push = accept && (word_done || key_last);
    entry.seed = seed_next;
    entry.word = word_next;
    entry.full = word_done;
    entry.last = key_last;
    entry.key_len = key_length_next;
    entry.ovf = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_assembly <= '0;
      byte_in_word <= '0;
      key_length <= '0;
      overflow_seen <= 1'b0;
      key_seed <= SEED_RESET;
    end else if (accept) begin
      key_seed <= seed_next;
      if (key_last) begin
        word_assembly <= '0;
        byte_in_word <= '0;
        key_length <= '0;
        overflow_seen <= 1'b0;
      end else begin
        word_assembly <= word_done ? 32'd0 : word_next;
        byte_in_word <= byte_in_word + 2'd1;
        key_length <= key_length_next;
        overflow_seen <= overflow_next;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst) key_length <= MAX_LEN)
    else $error("key length beyond bound");

  a_word_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_in_word == 2'd3) |=> (byte_in_word == 2'd0 && word_assembly == 32'd0))
    else $error("word not cleared after push");

endmodule

>>> hdl/m3ph_queue.sv
// small fifo between front end and hash engine
module m3ph_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  m3ph_pkg::m3ph_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output m3ph_pkg::m3ph_entry_t head_entry
);
  import m3ph_pkg::*;

  m3ph_entry_t        slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_pop;

  assign full = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (Q_PTR_W'(rd_ptr + Q_PTR_W'(count)) == wr_ptr))
    else $error("queue pointers disagree with count");

endmodule

>>> hdl/m3ph_back.sv
// hash engine: word mixing, finalizer, partition remainder and result register
module m3ph_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  m3ph_pkg::m3ph_entry_t q_entry,
  output logic                  q_pop,
  input  logic [15:0]           partition_count,
  input  logic [15:0]           local_partition,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           key_hash,
  output logic [15:0]           home_partition,
  output logic                  is_local,
  output logic                  length_overflow
);
  import m3ph_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_MIX  = 4'd3;
  localparam logic [3:0] S_FIN0 = 4'd4;
  localparam logic [3:0] S_FIN1 = 4'd5;
  localparam logic [3:0] S_FIN2 = 4'd6;
  localparam logic [3:0] S_FIN3 = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state;
  logic        new_key;
  logic [4:0]  div_cnt;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] dvd;
  logic [15:0] rem;
  m3ph_entry_t cur;

  logic [15:0] div_eff;
  logic [31:0] k_rot;
  logic [31:0] hk;
  logic [31:0] h_rot;
  logic [31:0] h_mixed;
  logic [31:0] h_fin0;
  logic [31:0] h_fin2;
  logic [16:0] trial;
  logic        trial_ge;
  logic        out_free;

  always_comb begin
    div_eff = (partition_count == 16'd0) ? 16'd1 : partition_count;
    k_rot = {k[16:0], k[31:17]};
    hk = h ^ k;
    h_rot = {hk[18:0], hk[31:19]};
    h_mixed = (h_rot << 2) + h_rot + MIX_ADD;
    h_fin0 = h ^ 32'(cur.key_len);
    h_fin0 = h_fin0 ^ (h_fin0 >> 16);
    h_fin2 = h ^ (h >> 13);
    trial = {rem, dvd[31]};
    trial_ge = (trial >= {1'b0, div_eff});
    out_free = !out_valid || !out_stall;
    q_pop = (state == S_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      new_key <= 1'b1;
      div_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            new_key <= 1'b0;
            state <= S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MIX;
        S_MIX:  state <= cur.last ? S_FIN0 : S_IDLE;
        S_FIN0: state <= S_FIN1;
        S_FIN1: state <= S_FIN2;
        S_FIN2: state <= S_FIN3;
        S_FIN3: begin
          div_cnt <= 5'd31;
          state <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            new_key <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur <= q_entry;
          k <= q_entry.word;
          if (new_key) begin
            h <= q_entry.seed;
          end
        end
      end
      S_MUL1: k <= k * MIX_C1;
      S_MUL2: k <= k_rot * MIX_C2;
      S_MIX:  h <= cur.full ? h_mixed : hk;
      S_FIN0: h <= h_fin0;
      S_FIN1: h <= h * FIN_M1;
      S_FIN2: h <= h_fin2 * FIN_M2;
      S_FIN3: begin
        h <= h ^ (h >> 16);
        dvd <= h ^ (h >> 16);
        rem <= '0;
      end
      S_DIV: begin
        rem <= trial_ge ? 16'(trial - {1'b0, div_eff}) : trial[15:0];
        dvd <= {dvd[30:0], 1'b0};
      end
      S_OUT: begin
        if (out_free) begin
          key_hash <= h;
          home_partition <= rem;
          is_local <= (rem == local_partition);
          length_overflow <= cur.ovf;
        end
      end
      default: ;
    endcase
  end

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_valid) |=> (state == S_MUL1 && !new_key))
    else $error("entry popped without starting mix");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_OUT) |-> (rem < div_eff))
    else $error("remainder not below divisor");

  a_result_key_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> cur.last)
    else $error("result for an entry that does not end a key");

endmodule

>>> test/murmur3_partition_hasher_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the murmur3 partition hasher top level
module murmur3_partition_hasher_top_test;

  localparam int AW = m3ph_pkg::PADDR_W;
  localparam logic [31:0] HASH_C1 = 32'hcc9e2d51;
  localparam logic [31:0] HASH_C2 = 32'h1b873593;
  localparam logic [31:0] ROUND_ADD = 32'he6546b64;
  localparam logic [31:0] FMIX_M1 = 32'h85ebca6b;
  localparam logic [31:0] FMIX_M2 = 32'hc2b2ae35;
  localparam int KEY_CAP = 256;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 110;
  localparam int MAX_REPORTS = 10;
  localparam int LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] home;
    logic        hit;
    logic        ovf;
  } hash_result_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [15:0] home;
    logic        hit;
    logic        ovf;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  key_byte;
  logic        key_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] key_hash;
  logic [15:0] home_partition;
  logic        is_local;
  logic        length_overflow;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [31:0] seed_reg;
  logic [15:0] count_reg;
  logic [15:0] own_reg;
  logic [31:0] run_hash;
  logic [31:0] word_acc;
  logic [1:0]  byte_pos;
  int          key_len;
  logic        key_overflow;
  hash_result_t expected_results[$];

  int  mismatches = 0;
  int  hashes_checked = 0;
  int  bytes_sent = 0;
  int  keys_sent = 0;
  int  settings_applied = 0;
  int  in_stall_cycles = 0;
  int  send_mode = 1;
  int  recv_mode = 1;
  bit  hold_request = 1'b0;

  stim_row_t directed_rows [22] = '{
    '{8'hff, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0},
    '{8'h01, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h7f, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0},
    '{8'hff, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0},
    '{8'h6b, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h65, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h79, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'hff, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'haa, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0},
    '{8'h55, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0}
  };

  murmur3_partition_hasher_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key_byte(key_byte),
    .key_last(key_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_hash(key_hash),
    .home_partition(home_partition),
    .is_local(is_local),
    .length_overflow(length_overflow),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic void note_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * HASH_C1;
    t = {t[16:0], t[31:17]};
    return t * HASH_C2;
  endfunction

  function automatic void hash_key_byte(input logic [7:0] data, input logic last);
    logic [31:0] h;
    logic [15:0] divisor;
    hash_result_t res;
    if (key_len == 0) run_hash = seed_reg;
    if (key_len < KEY_CAP) key_len++;
    else key_overflow = 1'b1;
    word_acc = word_acc | (32'(data) << (8 * byte_pos));
    byte_pos = byte_pos + 2'd1;
    if (byte_pos == 2'd0) begin
      run_hash = run_hash ^ scramble(word_acc);
      run_hash = {run_hash[18:0], run_hash[31:19]};
      run_hash = run_hash * 32'd5 + ROUND_ADD;
      word_acc = '0;
    end
    if (last) begin
      h = run_hash;
      if (byte_pos != 2'd0) h = h ^ scramble(word_acc);
      h = h ^ 32'(key_len);
      h = h ^ (h >> 16);
      h = h * FMIX_M1;
      h = h ^ (h >> 13);
      h = h * FMIX_M2;
      h = h ^ (h >> 16);
      divisor = (count_reg == 16'd0) ? 16'd1 : count_reg;
      res.hash = h;
      res.home = 16'(h % {16'd0, divisor});
      res.hit = (res.home == own_reg);
      res.ovf = key_overflow;
      expected_results.push_back(res);
      run_hash = seed_reg;
      word_acc = '0;
      byte_pos = '0;
      key_len = 0;
      key_overflow = 1'b0;
    end
  endfunction

  function automatic int idle_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_key_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 24);
    return $urandom_range(25, 64);
  endfunction

  // entered and left at a falling edge
  task automatic offer_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = idle_gap(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    key_byte <= data;
    key_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    hash_key_byte(data, last);
    bytes_sent++;
    if (last) keys_sent++;
    @(negedge clk);
  endtask

  task automatic send_key(input int len);
    for (int i = 0; i < len; i++) begin
      offer_byte(random_byte(), i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      m3ph_pkg::REG_HASH_SEED: seed_reg = value;
      m3ph_pkg::REG_PART_COUNT: count_reg = value[15:0];
      m3ph_pkg::REG_LOCAL_PART: own_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want, input int bits);
    logic [31:0] got;
    logic [31:0] mask;
    mask = (bits >= 32) ? 32'hffffffff : ((32'd1 << bits) - 32'd1);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AW'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if ((got & mask) !== (want & mask)) begin
      note_mismatch($sformatf("register %0d read %h, expected %h", idx, got & mask, want & mask));
    end
  endtask

  task automatic apply_setting(input logic [31:0] seed, input logic [15:0] count,
                               input logic [15:0] own);
    wait_idle();
    write_reg(m3ph_pkg::REG_HASH_SEED, seed);
    write_reg(m3ph_pkg::REG_PART_COUNT, {16'd0, count});
    write_reg(m3ph_pkg::REG_LOCAL_PART, {16'd0, own});
    check_reg(m3ph_pkg::REG_HASH_SEED, seed, 32);
    check_reg(m3ph_pkg::REG_PART_COUNT, {16'd0, count}, 16);
    check_reg(m3ph_pkg::REG_LOCAL_PART, {16'd0, own}, 16);
    settings_applied++;
  endtask

  always @(posedge clk) begin : result_check
    hash_result_t want;
    hash_result_t got;
    if (rst === 1'b0) begin
      if (in_valid && in_stall === 1'b1) in_stall_cycles++;
      if (out_valid === 1'b1 && !out_stall) begin
        got.hash = key_hash;
        got.home = home_partition;
        got.hit = is_local;
        got.ovf = length_overflow;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result hash %h home %0d", got.hash, got.home));
        end else begin
          want = expected_results.pop_front();
          hashes_checked++;
          if (got.hash !== want.hash || got.home !== want.home ||
              got.hit !== want.hit || got.ovf !== want.ovf) begin
            note_mismatch($sformatf(
              "hash %h/%h home %0d/%0d local %b/%b overflow %b/%b (got/expected)",
              got.hash, want.hash, got.home, want.home, got.hit, want.hit,
              got.ovf, want.ovf));
          end
        end
      end
    end
  end

  initial begin : result_side
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && run_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_left = HOLD_CYCLES;
        end else if (recv_mode != 0) begin
          stall_left = idle_gap(recv_mode);
          run_left = $urandom_range(1, 12);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left > 0) run_left--;
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("murmur3_partition_hasher_top_test failed");
    $finish;
  end

  initial begin : stimulus
    hash_result_t typed_res;
    int count_pick;
    int phase_start;
    rst = 1'b1;
    in_valid = 1'b0;
    key_byte = '0;
    key_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    seed_reg = 32'd42;
    count_reg = 16'd1;
    own_reg = 16'd0;
    run_hash = 32'd42;
    word_acc = '0;
    byte_pos = '0;
    key_len = 0;
    key_overflow = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    check_reg(m3ph_pkg::REG_HASH_SEED, 32'd42, 32);
    check_reg(m3ph_pkg::REG_PART_COUNT, 32'd1, 16);
    check_reg(m3ph_pkg::REG_LOCAL_PART, 32'd0, 16);

    // tail lengths 0..3 and extreme bytes under the reset setting
    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].data, directed_rows[i].last);
      if (directed_rows[i].typed) begin
        typed_res = expected_results.pop_back();
        typed_res.home = directed_rows[i].home;
        typed_res.hit = directed_rows[i].hit;
        typed_res.ovf = directed_rows[i].ovf;
        expected_results.push_back(typed_res);
      end
    end

    // seed changed mid-key only applies to the next key
    for (int i = 0; i < 5; i++) offer_byte(8'(i * 37 + 11), 1'b0);
    wait_idle();
    write_reg(m3ph_pkg::REG_HASH_SEED, 32'hdeadbeef);
    offer_byte(8'h5a, 1'b1);
    offer_byte(8'hc3, 1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          apply_setting(32'h0, 16'hffff, 16'hfffe);
          send_mode = 1;
          recv_mode = 1;
        end
        1: begin
          apply_setting(32'hffffffff, 16'h0, 16'h0);
        end
        2: begin
          apply_setting($urandom, 16'd1, 16'hffff);
        end
        3: begin
          apply_setting($urandom, 16'd2, 16'd1);
        end
        4: begin
          apply_setting($urandom, 16'd7, 16'd3);
          send_mode = 0;
          recv_mode = 0;
          hold_request = 1'b1;
        end
        5: begin
          count_pick = $urandom_range(1, 65535);
          apply_setting($urandom, 16'(count_pick), 16'($urandom_range(0, count_pick - 1)));
          send_mode = 1;
          recv_mode = 1;
          send_key(KEY_CAP);
          send_key(KEY_CAP + 1);
        end
        6: begin
          apply_setting($urandom, 16'd16, 16'd5);
          send_mode = 0;
          recv_mode = 0;
        end
        default: begin
          apply_setting($urandom, 16'd3, 16'd2);
          send_mode = 1;
          recv_mode = 1;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_key(pick_key_len());
    end

    wait_idle();
    $display("ran %0d key bytes in %0d keys over %0d register settings, %0d hashes compared",
             bytes_sent, keys_sent, settings_applied, hashes_checked);
    $display("keys at and past the length bound included; input stalled %0d cycles",
             in_stall_cycles);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("murmur3_partition_hasher_top_test passed");
    end else begin
      $display("murmur3_partition_hasher_top_test failed");
    end
    $finish;
  end

endmodule
